// ----- src/impact_energy_meter_defines.svh -----
// ----------------------------------------------------------------------------
// impact_energy_meter_defines.svh
// Assertion macros for the impact energy meter. With SYNTH defined the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef IMPACT_ENERGY_METER_DEFINES_SVH
`define IMPACT_ENERGY_METER_DEFINES_SVH

`ifndef SYNTH

// Check a property at each rising edge, ignored while reset is low
`define IEM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("impact_energy_meter: assertion failed");

// Check a property at each rising edge, reset included
`define IEM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("impact_energy_meter: assertion failed");

`else

`define IEM_ASSERT(label, clk, rst_n, prop)
`define IEM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- src/iem_pkg.sv -----
// ----------------------------------------------------------------------------
// iem_pkg
// Shared types and constants of the impact energy meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iem_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned MARGIN_W   = 12;
    localparam int unsigned DRIFT_W    = 8;
    localparam int unsigned GAIN_W     = 8;
    localparam int unsigned LIMIT_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned BASE_W     = 13;
    localparam int unsigned ENERGY_W   = 32;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 16;

    // Converter resolution; readings are masked to it
    localparam int unsigned SAMPLE_BITS  = 12;
    localparam int unsigned SAMPLE_EFF_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << SAMPLE_EFF_W) - 64'd1);

    // Calibration averaging
    localparam int unsigned CAL_SAMPLES = 50;
    localparam int unsigned CAL_CNT_W   = $clog2(CAL_SAMPLES + 1);
    localparam int unsigned CAL_SUM_W   =
        $clog2(CAL_SAMPLES * ((64'd1 << SAMPLE_EFF_W) - 64'd1) + 1);
    // Rounded-up reciprocal, exact floor for every sum below 2**CAL_SUM_W
    localparam int unsigned CAL_SHIFT   = CAL_SUM_W + 2 * $clog2(CAL_SAMPLES);
    localparam longint unsigned CAL_RECIP =
        ((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int unsigned CAL_RECIP_W = $clog2(CAL_RECIP + 1);
    localparam int unsigned CAL_PROD_W  = CAL_SUM_W + CAL_RECIP_W;

    // Intensity product width
    localparam int unsigned INT_PROD_W = ENERGY_W + GAIN_W;
    localparam int unsigned THR_W      = BASE_W + 1;

    // Register reset values
    localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(4);
    localparam logic [DRIFT_W-1:0]  DRIFT_RST  = DRIFT_W'(15);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(15);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(5000);

    // Result kinds
    localparam logic KIND_BASELINE  = 1'b0;
    localparam logic KIND_INTENSITY = 1'b1;

    // Command codes
    typedef enum logic [1:0] {
        CMD_CALIB  = 2'd0,
        CMD_START  = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_MARGIN    = 2'd0,
        REG_DRIFT_OFFSET    = 2'd1,
        REG_GAIN            = 2'd2,
        REG_INTENSITY_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_cmd                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic                sample_ok;
        logic [WINDOW_W-1:0] window_ms;
    } t_item;

    typedef struct packed {
        logic [MARGIN_W-1:0] noise_margin;
        logic [DRIFT_W-1:0]  drift_offset;
        logic [GAIN_W-1:0]   gain;
        logic [LIMIT_W-1:0]  intensity_limit;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [DATA_W-1:0] value;
    } t_result;

endpackage

// ----- src/iem_calib.sv -----
// ----------------------------------------------------------------------------
// iem_calib
// Calibration accumulator: sums a fixed count of readings and turns the
// average plus drift offset into the baseline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "impact_energy_meter_defines.svh"

module iem_calib import iem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_item             i_item,
    input  t_cfg              i_cfg,
    output logic [BASE_W-1:0] o_baseline,
    output t_result           o_result
);

    logic [CAL_SUM_W-1:0]  r_sum, n_sum;
    logic [CAL_CNT_W-1:0]  r_count, n_count;
    logic [BASE_W-1:0]     r_baseline, n_baseline;

    logic [CAL_SUM_W-1:0]  w_sum_add;
    logic [CAL_CNT_W-1:0]  w_count_inc;
    logic [CAL_PROD_W-1:0] w_prod;
    logic [BASE_W-1:0]     w_quot;
    logic [BASE_W-1:0]     w_baseline_new;

    // Accumulate; failed conversions add nothing
    assign w_sum_add   = r_sum + (i_item.sample_ok ? CAL_SUM_W'(i_item.sample) : '0);
    assign w_count_inc = r_count + 1'b1;

    // Divide by the sample count through the reciprocal
    assign w_prod         = CAL_PROD_W'(w_sum_add) * CAL_PROD_W'(CAL_RECIP);
    assign w_quot         = BASE_W'(w_prod >> CAL_SHIFT);
    assign w_baseline_new = w_quot + BASE_W'(i_cfg.drift_offset);

    // Next state and result
    always_comb begin
        n_sum          = r_sum;
        n_count        = r_count;
        n_baseline     = r_baseline;
        o_result.valid = 1'b0;
        o_result.kind  = KIND_BASELINE;
        o_result.value = DATA_W'(w_baseline_new);
        if (i_fire && (i_item.cmd == CMD_CALIB)) begin
            if (w_count_inc >= CAL_CNT_W'(CAL_SAMPLES)) begin
                n_sum          = '0;
                n_count        = '0;
                n_baseline     = w_baseline_new;
                o_result.valid = 1'b1;
            end else begin
                n_sum   = w_sum_add;
                n_count = w_count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_baseline <= '0;
        end else begin
            r_sum      <= n_sum;
            r_count    <= n_count;
            r_baseline <= n_baseline;
        end
    end

    assign o_baseline = r_baseline;

    `IEM_ASSERT(a_count_below_total, i_clk, i_rst_n, r_count < CAL_CNT_W'(CAL_SAMPLES))
    `IEM_ASSERT(a_done_clears, i_clk, i_rst_n, o_result.valid |=> (r_count == '0) && (r_sum == '0))

endmodule

// ----- src/iem_window.sv -----
// ----------------------------------------------------------------------------
// iem_window
// Listen window: counts ticks, sums the excess over the baseline of valid
// readings over the threshold; reports gained, clamped energy at window end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "impact_energy_meter_defines.svh"

module iem_window import iem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_item             i_item,
    input  t_cfg              i_cfg,
    input  logic [BASE_W-1:0] i_baseline,
    output t_result           o_result
);

    logic [ENERGY_W-1:0]   r_energy, n_energy;
    logic                  r_open, n_open;
    logic [WINDOW_W-1:0]   r_elapsed, n_elapsed;
    logic [WINDOW_W-1:0]   r_wlen, n_wlen;

    logic [THR_W-1:0]      w_thr;
    logic                  w_hit;
    logic [BASE_W-1:0]     w_diff;
    logic [ENERGY_W:0]     w_energy_add;
    logic [ENERGY_W-1:0]   w_energy_sat;
    logic [WINDOW_W-1:0]   w_elapsed_inc;
    logic [INT_PROD_W-1:0] w_prod;
    logic [DATA_W-1:0]     w_intensity;

    // Threshold test and excess over baseline
    assign w_thr  = THR_W'(i_baseline) + THR_W'(i_cfg.noise_margin);
    assign w_hit  = r_open && i_item.sample_ok && (THR_W'(i_item.sample) > w_thr);
    assign w_diff = BASE_W'(i_item.sample) - i_baseline;

    // Saturating energy add
    assign w_energy_add = (ENERGY_W + 1)'(r_energy) + (ENERGY_W + 1)'(w_diff);
    assign w_energy_sat = w_energy_add[ENERGY_W] ? '1 : w_energy_add[ENERGY_W-1:0];

    // Tick count and clamped intensity
    assign w_elapsed_inc = r_elapsed + 1'b1;
    assign w_prod        = INT_PROD_W'(r_energy) * INT_PROD_W'(i_cfg.gain);
    assign w_intensity   = (w_prod > INT_PROD_W'(i_cfg.intensity_limit)) ?
                           DATA_W'(i_cfg.intensity_limit) : w_prod[DATA_W-1:0];

    // Next state and result
    always_comb begin
        n_energy       = r_energy;
        n_open         = r_open;
        n_elapsed      = r_elapsed;
        n_wlen         = r_wlen;
        o_result.valid = 1'b0;
        o_result.kind  = KIND_INTENSITY;
        o_result.value = '0;
        if (i_fire) begin
            unique case (i_item.cmd)
                CMD_START: begin
                    n_energy  = '0;
                    n_elapsed = '0;
                    n_wlen    = i_item.window_ms;
                    if (i_item.window_ms == '0) begin
                        n_open         = 1'b0;
                        o_result.valid = 1'b1;
                    end else begin
                        n_open = 1'b1;
                    end
                end
                CMD_SAMPLE: begin
                    if (w_hit) begin
                        n_energy = w_energy_sat;
                    end
                end
                CMD_TICK: begin
                    if (r_open) begin
                        n_elapsed = w_elapsed_inc;
                        if (w_elapsed_inc >= r_wlen) begin
                            n_open         = 1'b0;
                            o_result.valid = 1'b1;
                            o_result.value = w_intensity;
                        end
                    end
                end
                CMD_CALIB: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy  <= '0;
            r_open    <= 1'b0;
            r_elapsed <= '0;
            r_wlen    <= '0;
        end else begin
            r_energy  <= n_energy;
            r_open    <= n_open;
            r_elapsed <= n_elapsed;
            r_wlen    <= n_wlen;
        end
    end

    `IEM_ASSERT(a_open_has_length, i_clk, i_rst_n, r_open |-> (r_wlen != '0))
    `IEM_ASSERT(a_ticks_below_length, i_clk, i_rst_n, r_open |-> (r_elapsed < r_wlen))
    `IEM_ASSERT(a_done_closes, i_clk, i_rst_n, (i_fire && (i_item.cmd == CMD_TICK) && o_result.valid) |=> !r_open)

endmodule

// ----- src/impact_energy_meter.sv -----
// ----------------------------------------------------------------------------
// impact_energy_meter
// Baseline-calibrated threshold energy integrator for an impact sensor.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the slave stream: tuser carries the command (calibration
// sample, start window, measurement sample, millisecond tick), tdata the
// reading, its ok flag and the window length. Results leave on the master
// stream: tuser is the kind (baseline or intensity), tdata the value.
// Registers are to be written through the plain write port while the block
// idles; the block itself does not enforce this. Each request is held in an
// input register; once the output register is free, the calibration and
// window logic update their state and a result, if any, goes into the
// output register. One request is taken every cycle while the receiver does
// not stall, in a single pass through the accumulate, compare and 32x8 gain
// multiply. When the receiver stalls, the held result waits; one more request
// is taken only into an empty input register, and tready stays low until the
// result is taken. Reset (synchronous, active low) clears the baseline, sums,
// counters and both stream stages and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "impact_energy_meter_defines.svh"

module impact_energy_meter import iem_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: sample[11:0], sample_ok[12], window_ms[28:13], zero[31:29]
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    // Result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: value[15:0]
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: result_kind[0]
    output logic                  o_m_axis_tuser,
    // Register write port
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    logic              r_out_kind;
    logic [DATA_W-1:0] r_out_value;

    logic              w_out_free;
    logic              w_fire;
    logic [BASE_W-1:0] w_baseline;
    t_result           w_cal_res;
    t_result           w_win_res;
    t_result           w_res;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_margin    <= MARGIN_RST;
            r_cfg.drift_offset    <= DRIFT_RST;
            r_cfg.gain            <= GAIN_RST;
            r_cfg.intensity_limit <= LIMIT_RST;
        end else if (i_cfg_wen) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_NOISE_MARGIN:    r_cfg.noise_margin    <= i_cfg_wdata[MARGIN_W-1:0];
                REG_DRIFT_OFFSET:    r_cfg.drift_offset    <= i_cfg_wdata[DRIFT_W-1:0];
                REG_GAIN:            r_cfg.gain            <= i_cfg_wdata[GAIN_W-1:0];
                REG_INTENSITY_LIMIT: r_cfg.intensity_limit <= i_cfg_wdata[LIMIT_W-1:0];
            endcase
        end
    end

    // Flow control: process the held request when the output slot frees
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.cmd       <= t_cmd'(i_s_axis_tuser);
            r_item.sample    <= i_s_axis_tdata[SAMPLE_W-1:0] & SAMPLE_MASK;
            r_item.sample_ok <= i_s_axis_tdata[SAMPLE_W];
            r_item.window_ms <= i_s_axis_tdata[SAMPLE_W+WINDOW_W:SAMPLE_W+1];
        end
    end

    iem_calib u_calib (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_item),
        .i_cfg      (r_cfg),
        .o_baseline (w_baseline),
        .o_result   (w_cal_res)
    );

    iem_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_item),
        .i_cfg      (r_cfg),
        .i_baseline (w_baseline),
        .o_result   (w_win_res)
    );

    // Pick the result of whichever unit produced one
    assign w_res = w_cal_res.valid ? w_cal_res : w_win_res;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_fire && w_res.valid) begin
            r_out_kind  <= w_res.kind;
            r_out_value <= w_res.value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_kind;

    `IEM_ASSERT(a_one_result_source, i_clk, i_rst_n, !(w_cal_res.valid && w_win_res.valid))

endmodule

// ----- tb/impact_energy_meter_tb.sv -----
// ----------------------------------------------------------------------------
// impact_energy_meter_tb
// Self-checking bench for the impact energy meter. A predictor class tracks
// calibration, window and energy state and queues the expected baseline and
// intensity reports; every report taken from the result stream is compared
// field by field. Stimulus is a short directed run followed by random
// calibration bursts, measurement windows and noise under several register
// settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module impact_energy_meter_tb;
    import iem_pkg::*;

    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE = 292;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned STALL_LIMIT     = 2000;

    typedef struct {
        logic              kind;
        logic [DATA_W-1:0] value;
    } t_meter_report;

    // Predictor of the meter: register copies, state and pending reports
    class energy_meter_model;
        logic [MARGIN_W-1:0] noise_margin;
        logic [DRIFT_W-1:0]  drift_offset;
        logic [GAIN_W-1:0]   gain;
        logic [LIMIT_W-1:0]  intensity_limit;
        int unsigned         baseline;
        int unsigned         calib_sum;
        int unsigned         calib_count;
        logic [ENERGY_W-1:0] energy_sum;
        bit                  window_open;
        logic [WINDOW_W-1:0] elapsed_ticks;
        logic [WINDOW_W-1:0] window_length;
        t_meter_report       reports[$];
        int unsigned         mismatches;

        function new();
            noise_margin    = MARGIN_RST;
            drift_offset    = DRIFT_RST;
            gain            = GAIN_RST;
            intensity_limit = LIMIT_RST;
            baseline        = 0;
            calib_sum       = 0;
            calib_count     = 0;
            energy_sum      = '0;
            window_open     = 1'b0;
            elapsed_ticks   = '0;
            window_length   = '0;
            mismatches      = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_NOISE_MARGIN:    noise_margin    = val[MARGIN_W-1:0];
                REG_DRIFT_OFFSET:    drift_offset    = val[DRIFT_W-1:0];
                REG_GAIN:            gain            = val[GAIN_W-1:0];
                REG_INTENSITY_LIMIT: intensity_limit = val[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_report(logic kind, logic [DATA_W-1:0] value);
            t_meter_report r;
            r.kind  = kind;
            r.value = value;
            reports.push_back(r);
        endfunction

        // Update state for one accepted request; return 0 if it was ignored
        function bit accept_request(t_item it);
            longint unsigned sum;
            longint unsigned prod;
            int unsigned     reading;
            reading = 32'(it.sample & SAMPLE_MASK);
            case (it.cmd)
                CMD_CALIB: begin
                    if (it.sample_ok)
                        calib_sum += reading;
                    calib_count++;
                    if (calib_count >= CAL_SAMPLES) begin
                        baseline    = calib_sum / CAL_SAMPLES + drift_offset;
                        calib_sum   = 0;
                        calib_count = 0;
                        push_report(KIND_BASELINE,
                                    baseline > 65535 ? 16'hFFFF : baseline[DATA_W-1:0]);
                    end
                end
                CMD_START: begin
                    energy_sum    = '0;
                    elapsed_ticks = '0;
                    window_length = it.window_ms;
                    window_open   = (it.window_ms != 0);
                    if (it.window_ms == 0)
                        push_report(KIND_INTENSITY, '0);
                end
                CMD_SAMPLE: begin
                    if (!window_open)
                        return 1'b0;
                    if (it.sample_ok && reading > baseline + noise_margin) begin
                        sum = 64'(energy_sum) + 64'(reading - baseline);
                        energy_sum = (sum > 64'hFFFF_FFFF) ? '1 : sum[ENERGY_W-1:0];
                    end
                end
                default: begin
                    if (!window_open)
                        return 1'b0;
                    elapsed_ticks = elapsed_ticks + 1'b1;
                    if (elapsed_ticks >= window_length) begin
                        window_open = 1'b0;
                        prod = 64'(energy_sum) * 64'(gain);
                        if (prod > 64'hFFFF_FFFF)
                            prod = 64'hFFFF_FFFF;
                        if (prod > 64'(intensity_limit))
                            prod = 64'(intensity_limit);
                        push_report(KIND_INTENSITY, prod[DATA_W-1:0]);
                    end
                end
            endcase
            return 1'b1;
        endfunction

        // Compare one report from the result stream with the oldest expected one
        function void compare_report(logic kind, logic [DATA_W-1:0] value);
            t_meter_report exp_r;
            if (reports.size() == 0) begin
                $display("%0t: unexpected report: kind %0d value %0d",
                         $time, kind, value);
                mismatches++;
                return;
            end
            exp_r = reports.pop_front();
            if (kind !== exp_r.kind) begin
                $display("%0t: report kind mismatch: expected %0d actual %0d",
                         $time, exp_r.kind, kind);
                mismatches++;
            end
            if (value !== exp_r.value) begin
                $display("%0t: report value mismatch: expected %0d actual %0d",
                         $time, exp_r.value, value);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata;
    logic [1:0]            i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    energy_meter_model model = new();
    int unsigned       snd_idle_pct = 35;
    int unsigned       rcv_idle_pct = 78;
    int unsigned       items_done   = 0;

    impact_energy_meter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_item make_item(t_cmd c, logic [SAMPLE_W-1:0] s, logic ok,
                                        logic [WINDOW_W-1:0] w);
        t_item it;
        it.cmd       = c;
        it.sample    = s;
        it.sample_ok = ok;
        it.window_ms = w;
        return it;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_reading(int v);
        if (v < 0)
            return '0;
        if (v > int'(SAMPLE_MASK))
            return SAMPLE_MASK;
        return v[SAMPLE_W-1:0];
    endfunction

    // Measurement reading: half near the counting threshold, the rest random or extreme
    function automatic logic [SAMPLE_W-1:0] pick_reading();
        int unsigned r;
        int          thr;
        r   = $urandom_range(0, 99);
        thr = int'(model.baseline + model.noise_margin);
        if (r < 50)
            return clamp_reading(thr + int'($urandom_range(0, 16)) - 8);
        if (r < 80)
            return SAMPLE_W'($urandom_range(0, 4095));
        return ($urandom_range(0, 1) != 0) ? SAMPLE_MASK : '0;
    endfunction

    // Offer one request with random gaps, hold it until accepted
    task automatic send_request(t_item it);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, it.window_ms, it.sample_ok, it.sample};
        i_s_axis_tuser  <= it.cmd;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        if (model.accept_request(it))
            items_done++;
    endtask

    // Hold off the sender until every expected report has come back
    task automatic drain_reports();
        i_s_axis_tvalid <= 1'b0;
        while (model.reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [CFG_DATA_W-1:0] margin, logic [CFG_DATA_W-1:0] drift,
                                  logic [CFG_DATA_W-1:0] gain_v, logic [CFG_DATA_W-1:0] limit);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= REG_NOISE_MARGIN;
        i_cfg_wdata <= margin;
        model.write_reg(REG_NOISE_MARGIN, margin);
        @(posedge i_clk);
        i_cfg_idx   <= REG_DRIFT_OFFSET;
        i_cfg_wdata <= drift;
        model.write_reg(REG_DRIFT_OFFSET, drift);
        @(posedge i_clk);
        i_cfg_idx   <= REG_GAIN;
        i_cfg_wdata <= gain_v;
        model.write_reg(REG_GAIN, gain_v);
        @(posedge i_clk);
        i_cfg_idx   <= REG_INTENSITY_LIMIT;
        i_cfg_wdata <= limit;
        model.write_reg(REG_INTENSITY_LIMIT, limit);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Feed calibration samples until a baseline report is due
    task automatic run_calibration();
        int unsigned r;
        int          center;
        int          spread;
        r      = $urandom_range(0, 9);
        center = (r == 0) ? 0 : (r == 1) ? int'(SAMPLE_MASK) : int'($urandom_range(0, 4095));
        spread = $urandom_range(0, 64);
        do
            send_request(make_item(CMD_CALIB,
                                   clamp_reading(center + int'($urandom_range(0, 2 * spread))
                                                 - spread),
                                   $urandom_range(0, 9) != 0, WINDOW_W'($urandom)));
        while (model.calib_count != 0);
    endtask

    // Open a window and drive samples and ticks until it closes
    task automatic run_window();
        int unsigned         r;
        logic [WINDOW_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 20)
            len = WINDOW_W'($urandom_range(7, 20));
        else
            len = WINDOW_W'($urandom_range(1, 6));
        // occasionally open a very long window first and restart it
        if (r >= 95)
            send_request(make_item(CMD_START, pick_reading(), 1'b1, '1));
        send_request(make_item(CMD_START, pick_reading(), 1'($urandom_range(0, 1)), len));
        while (model.window_open) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_request(make_item(CMD_TICK, SAMPLE_W'($urandom),
                                       1'($urandom_range(0, 1)), WINDOW_W'($urandom)));
            else if (r < 90)
                send_request(make_item(CMD_SAMPLE, pick_reading(), $urandom_range(0, 9) != 0,
                                       WINDOW_W'($urandom)));
            else if (r < 95)
                send_request(make_item(CMD_CALIB, pick_reading(), 1'($urandom_range(0, 1)),
                                       WINDOW_W'($urandom)));
            else if (r < 97)
                send_request(make_item(CMD_START, pick_reading(), 1'b1,
                                       WINDOW_W'($urandom_range(1, 4))));
            else
                send_request(make_item(CMD_SAMPLE, SAMPLE_MASK, 1'b0, WINDOW_W'($urandom)));
        end
    endtask

    task automatic send_noise();
        logic [WINDOW_W-1:0] w;
        w = ($urandom_range(0, 1) != 0) ? WINDOW_W'($urandom) : WINDOW_W'($urandom_range(0, 3));
        send_request(make_item(t_cmd'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                               1'($urandom_range(0, 1)), w));
    endtask

    // Result side: check accepted reports, stall at random
    initial begin : result_sink
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                model.compare_report(o_m_axis_tuser, o_m_axis_tdata);
            i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Abort if neither stream moves for too long
    initial begin : stall_watchdog
        int unsigned quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("impact_energy_meter regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned target;
        int unsigned r;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_CALIB;
        i_cfg_wen       <= 1'b0;
        i_cfg_idx       <= REG_NOISE_MARGIN;
        i_cfg_wdata     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed run on reset defaults (baseline still zero)
        send_request(make_item(CMD_TICK, SAMPLE_MASK, 1'b1, '1));     // tick while closed
        send_request(make_item(CMD_SAMPLE, SAMPLE_MASK, 1'b1, '0));   // sample while closed
        send_request(make_item(CMD_START, '0, 1'b0, '0));             // zero-length window
        send_request(make_item(CMD_START, SAMPLE_MASK, 1'b1, '1));    // longest window
        send_request(make_item(CMD_START, '0, 1'b0, 16'd2));          // restart while open
        send_request(make_item(CMD_SAMPLE, SAMPLE_MASK, 1'b1, '0));
        send_request(make_item(CMD_SAMPLE, SAMPLE_MASK, 1'b0, '0));   // failed conversion
        send_request(make_item(CMD_SAMPLE, 12'd4, 1'b1, '0));         // exactly at threshold
        send_request(make_item(CMD_SAMPLE, 12'd5, 1'b1, '0));         // just above it
        send_request(make_item(CMD_CALIB, '0, 1'b0, '0));             // failed calibration
        send_request(make_item(CMD_TICK, '0, 1'b0, '0));
        send_request(make_item(CMD_SAMPLE, '0, 1'b1, '1));
        send_request(make_item(CMD_TICK, '0, 1'b0, '0));              // close, clamped
        send_request(make_item(CMD_TICK, '0, 1'b0, '0));
        send_request(make_item(CMD_START, '0, 1'b0, 16'd1));
        send_request(make_item(CMD_SAMPLE, 12'd10, 1'b1, '0));
        send_request(make_item(CMD_TICK, SAMPLE_MASK, 1'b1, '1));
        send_request(make_item(CMD_CALIB, SAMPLE_MASK, 1'b1, '1));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            snd_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 78 : 0;
            rcv_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 35 : 0;
            if (ph > 0) begin
                drain_reports();
                case (ph)
                    1: write_settings(16'd0, 16'd255, 16'd255, 16'hFFFF);
                    2: write_settings(16'd4095, 16'd0, 16'd1, 16'd0);
                    3: write_settings(CFG_DATA_W'($urandom_range(0, 200)),
                                      CFG_DATA_W'($urandom_range(0, 255)),
                                      CFG_DATA_W'($urandom_range(0, 255)),
                                      CFG_DATA_W'($urandom_range(0, 65535)));
                    4: write_settings(16'd0, 16'd0, 16'd0, 16'hFFFF);
                    default: write_settings(CFG_DATA_W'($urandom_range(0, 40)),
                                            CFG_DATA_W'($urandom_range(0, 255)),
                                            CFG_DATA_W'($urandom_range(1, 255)),
                                            CFG_DATA_W'($urandom_range(0, 65535)));
                endcase
            end
            target = items_done + ITEMS_PER_PHASE;
            while (items_done < target) begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    run_calibration();
                else if (r < 80)
                    run_window();
                else
                    send_noise();
            end
        end

        drain_reports();
        if (model.mismatches == 0)
            $display("impact_energy_meter regression: pass");
        else
            $display("impact_energy_meter regression: fail");
        $finish;
    end

endmodule
